/* hw/rtl/twsa_pkg.sv */
// ----------------------------------------------------------------------------
// twsa_pkg
// shared constants and payload types for the traffic window statistics block
// ----------------------------------------------------------------------------
package twsa_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int BYTES_W      = 23;
    localparam int RATE_W       = 32;
    // window sum never exceeds WINDOW_DEPTH full-scale samples
    localparam int SUM_W        = RATE_W + PTR_W;

    localparam logic [BYTES_W-1:0] BYTES_SAT    = 23'd4473924;
    localparam logic [RATE_W-1:0]  BPS_PER_BYTE = 32'd480;
    localparam logic [RATE_W-1:0]  FLOOR_RESET  = 32'd1024;

    // 1-2-5 steps up to 2e9, ascending
    localparam int SCALE_N     = 29;
    localparam int SCALE_IDX_W = $clog2(SCALE_N);
    localparam logic [RATE_W-1:0] SCALE_STEPS [SCALE_N] = '{
        32'd1,         32'd2,         32'd5,
        32'd10,        32'd20,        32'd50,
        32'd100,       32'd200,       32'd500,
        32'd1000,      32'd2000,      32'd5000,
        32'd10000,     32'd20000,     32'd50000,
        32'd100000,    32'd200000,    32'd500000,
        32'd1000000,   32'd2000000,   32'd5000000,
        32'd10000000,  32'd20000000,  32'd50000000,
        32'd100000000, 32'd200000000, 32'd500000000,
        32'd1000000000, 32'd2000000000
    };

    typedef struct packed {
        logic [BYTES_W-1:0] in_bytes;
        logic [BYTES_W-1:0] out_bytes;
    } in_t;

    typedef struct packed {
        logic [RATE_W-1:0] window_max;
        logic [RATE_W-1:0] window_avg;
        logic [RATE_W-1:0] session_peak;
        logic [RATE_W-1:0] display_scale;
    } out_t;

endpackage

/* hw/rtl/traffic_window_stats_autoscale.sv */
// ----------------------------------------------------------------------------
// traffic_window_stats_autoscale
// sliding window max and mean of combined traffic rate, session peak, 1-2-5 scale
// ----------------------------------------------------------------------------
// one transaction at a time: an input is taken only in the idle state; the time per
//   transaction is set by the one-read-per-cycle sweep of the stored samples in
//   the sample ram and by the bit-serial divider
// a finished result waits in the output register while the next input is taken
// reset: rst_n async active low, clears pointer, fill flag, peak and scale_floor
//   (to 1024); sample ram contents are not cleared, only written entries are read
module traffic_window_stats_autoscale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  twsa_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output twsa_pkg::out_t              out_data,
    input  logic                        cfg_wr_en,
    input  logic [twsa_pkg::RATE_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_CALC,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    twsa_pkg::in_t                   in_reg;
    logic [twsa_pkg::RATE_W-1:0]     floor_reg;
    logic [twsa_pkg::PTR_W-1:0]      wp_reg;
    logic                            full_reg;
    logic [twsa_pkg::RATE_W-1:0]     peak_reg;
    logic [twsa_pkg::CNT_W-1:0]      count_reg;
    logic [twsa_pkg::CNT_W-1:0]      issue_reg;
    logic                            rd_valid_reg;
    logic [twsa_pkg::SUM_W-1:0]      sum_reg;
    logic [twsa_pkg::RATE_W-1:0]     wmax_reg;
    logic [twsa_pkg::RATE_W-1:0]     vmax_reg;
    logic [twsa_pkg::SCALE_IDX_W-1:0] sidx_reg;
    logic                            sdone_reg;
    logic [twsa_pkg::RATE_W-1:0]     scale_reg;
    logic                            out_valid_reg;
    twsa_pkg::out_t                  out_reg;

    logic [twsa_pkg::BYTES_W-1:0]    in_sat;
    logic [twsa_pkg::BYTES_W-1:0]    out_sat;
    logic [twsa_pkg::RATE_W-1:0]     combined;
    logic                            wp_wrap;
    logic                            ram_wr_en;
    logic                            ram_rd_en;
    logic [twsa_pkg::RATE_W-1:0]     ram_rd_data;
    logic                            scan_done;
    logic                            div_start;
    logic                            div_busy;
    logic [twsa_pkg::RATE_W-1:0]     div_quo;
    logic [twsa_pkg::RATE_W-1:0]     scale_step;
    logic                            out_load;

    always_comb
    begin
        in_sat   = (in_reg.in_bytes > twsa_pkg::BYTES_SAT) ? twsa_pkg::BYTES_SAT
                                                          : in_reg.in_bytes;
        out_sat  = (in_reg.out_bytes > twsa_pkg::BYTES_SAT) ? twsa_pkg::BYTES_SAT
                                                           : in_reg.out_bytes;
        // saturated counts keep the sum below 2^32
        combined = twsa_pkg::RATE_W'(in_sat) * twsa_pkg::BPS_PER_BYTE
                 + twsa_pkg::RATE_W'(out_sat) * twsa_pkg::BPS_PER_BYTE;
    end

    assign wp_wrap    = (wp_reg == twsa_pkg::PTR_W'(twsa_pkg::WINDOW_DEPTH - 1));
    assign ram_wr_en  = (state_reg == ST_WRITE);
    assign ram_rd_en  = (state_reg == ST_SCAN) && (issue_reg != count_reg);
    assign scan_done  = (state_reg == ST_SCAN) && (issue_reg == count_reg) && !rd_valid_reg;
    assign div_start  = scan_done;
    assign scale_step = twsa_pkg::SCALE_STEPS[sidx_reg];
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    twsa_ram #(
        .WIDTH (twsa_pkg::RATE_W),
        .DEPTH (twsa_pkg::WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (combined),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg[twsa_pkg::PTR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    twsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_reg        <= '0;
            floor_reg     <= twsa_pkg::FLOOR_RESET;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            peak_reg      <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            wmax_reg      <= '0;
            vmax_reg      <= '0;
            sidx_reg      <= '0;
            sdone_reg     <= 1'b0;
            scale_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                floor_reg <= cfg_wr_data;
            end

            // a new result replaces one leaving in the same cycle
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_valid_reg <= ram_rd_en;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_reg    <= in_data;
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    wp_reg <= wp_wrap ? '0 : wp_reg + 1'b1;
                    if (wp_wrap)
                    begin
                        full_reg <= 1'b1;
                    end
                    if (combined > peak_reg)
                    begin
                        peak_reg <= combined;
                    end
                    count_reg <= (full_reg || wp_wrap)
                               ? twsa_pkg::CNT_W'(twsa_pkg::WINDOW_DEPTH)
                               : twsa_pkg::CNT_W'(wp_reg) + 1'b1;
                    issue_reg <= '0;
                    sum_reg   <= '0;
                    wmax_reg  <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (ram_rd_en)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    // read data is registered and arrives in the cycle after its address
                    if (rd_valid_reg)
                    begin
                        sum_reg <= sum_reg + twsa_pkg::SUM_W'(ram_rd_data);
                        if (ram_rd_data > wmax_reg)
                        begin
                            wmax_reg <= ram_rd_data;
                        end
                    end
                    if (scan_done)
                    begin
                        vmax_reg  <= (wmax_reg > floor_reg) ? wmax_reg : floor_reg;
                        sidx_reg  <= '0;
                        sdone_reg <= 1'b0;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    // scale search runs alongside the divider
                    if (!sdone_reg)
                    begin
                        if (scale_step >= vmax_reg)
                        begin
                            scale_reg <= scale_step;
                            sdone_reg <= 1'b1;
                        end
                        else if (sidx_reg == twsa_pkg::SCALE_IDX_W'(twsa_pkg::SCALE_N - 1))
                        begin
                            scale_reg <= vmax_reg;
                            sdone_reg <= 1'b1;
                        end
                        else
                        begin
                            sidx_reg <= sidx_reg + 1'b1;
                        end
                    end
                    if (!div_busy && sdone_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_reg.window_max    <= wmax_reg;
                        out_reg.window_avg    <= div_quo;
                        out_reg.session_peak  <= peak_reg;
                        out_reg.display_scale <= scale_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hw/rtl/twsa_ram.sv */
// ----------------------------------------------------------------------------
// twsa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module twsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/twsa_div.sv */
// ----------------------------------------------------------------------------
// twsa_div
// restoring divider, one quotient bit per cycle, window sum by sample count
// ----------------------------------------------------------------------------
module twsa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [twsa_pkg::SUM_W-1:0]  dividend,
    input  logic [twsa_pkg::CNT_W-1:0]  divisor,
    output logic                        busy,
    output logic [twsa_pkg::RATE_W-1:0] quotient
);

    localparam int STEP_W = $clog2(twsa_pkg::SUM_W + 1);

    logic [twsa_pkg::CNT_W-1:0] rem_reg;
    logic [twsa_pkg::CNT_W-1:0] rem_next;
    logic [twsa_pkg::SUM_W-1:0] quo_reg;
    logic [twsa_pkg::SUM_W-1:0] quo_next;
    logic [twsa_pkg::CNT_W-1:0] div_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic [twsa_pkg::CNT_W:0]   shifted;
    logic                       q_bit;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[twsa_pkg::SUM_W-1]};
        q_bit   = (shifted >= {1'b0, div_reg});
        if (q_bit)
        begin
            rem_next = twsa_pkg::CNT_W'(shifted - {1'b0, div_reg});
        end
        else
        begin
            rem_next = shifted[twsa_pkg::CNT_W-1:0];
        end
        quo_next = {quo_reg[twsa_pkg::SUM_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            div_reg  <= divisor;
            step_reg <= STEP_W'(twsa_pkg::SUM_W);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_reg - 1'b1;
            busy_reg <= (step_reg != STEP_W'(1));
        end
    end

    assign busy     = busy_reg;
    // mean of 32-bit samples always fits in 32 bits
    assign quotient = quo_reg[twsa_pkg::RATE_W-1:0];

endmodule

/* dv/traffic_window_stats_autoscale_tb.sv */
// ----------------------------------------------------------------------------
// traffic_window_stats_autoscale_tb
// self-checking bench for the traffic window statistics block: a directed
// table of corner cases, then randomized traffic phases at several scale
// floors; every result is checked, against the typed table values where given,
// else against an in-bench window/peak/scale predictor, with random idling on
// both sides and one long output hold-off
module traffic_window_stats_autoscale_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_PCT     = 7;
    localparam int HOLD_CYCLES  = 1500;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = twsa_pkg::WINDOW_DEPTH + 100;
    localparam int MAX_SHOWN    = 10;
    localparam int RW           = twsa_pkg::RATE_W;
    localparam int BW           = twsa_pkg::BYTES_W;

    localparam logic [RW-1:0] FULL_RATE    = 32'd4294967040;
    localparam logic [63:0]   SCALE_TOP    = 64'd2000000000;
    localparam logic [63:0]   MANTISSA [3] = '{64'd1, 64'd2, 64'd5};

    typedef enum logic {ROW_ITEM, ROW_FLOOR} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [RW-1:0]      floor_val;
        logic [BW-1:0]      in_b;
        logic [BW-1:0]      out_b;
        bit                 typed;
        twsa_pkg::out_t     stats;
    } stim_row_t;

    typedef struct {
        bit                random_floor;
        logic [RW-1:0]     floor_val;
        int                count;
        int                cap_bits;
        bit                steady_run;
    } phase_t;

    localparam int NUM_ROWS   = 22;
    localparam int NUM_PHASES = 9;

    // directed corners; typed results only where they are obvious
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_ITEM,  32'd0, 23'd0, 23'd0, 1'b1,
          '{32'd0, 32'd0, 32'd0, 32'd2000}},
        '{ROW_FLOOR, 32'd0, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd0, 23'd0, 1'b1,
          '{32'd0, 32'd0, 32'd0, 32'd1}},
        '{ROW_FLOOR, 32'd2000, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd1, 23'd0, 1'b1,
          '{32'd480, 32'd160, 32'd480, 32'd2000}},
        '{ROW_ITEM,  32'd0, 23'h7FFFFF, 23'h7FFFFF, 1'b1,
          '{FULL_RATE, 32'd1073741880, FULL_RATE, FULL_RATE}},
        '{ROW_ITEM,  32'd0, 23'd4473924, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd4473925, 23'd4473924, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'h555555, 23'h2AAAAA, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'h2AAAAA, 23'h555555, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'h400000, 23'd1, 1'b0, '0},
        '{ROW_FLOOR, 32'd2000000000, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_FLOOR, 32'd2000000001, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd3, 23'd7, 1'b0, '0},
        '{ROW_FLOOR, 32'hFFFFFFFF, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd100, 23'd200, 1'b0, '0},
        '{ROW_FLOOR, 32'h80000000, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd4473923, 23'd4473923, 1'b0, '0},
        '{ROW_FLOOR, 32'd1, 23'd0, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'h7FFFFF, 23'd0, 1'b0, '0},
        '{ROW_ITEM,  32'd0, 23'd0, 23'h7FFFFF, 1'b0, '0}
    };

    // small-value phases fill the window with low rates so a large floor can decide the scale
    phase_t traffic_phases [NUM_PHASES] = '{
        '{1'b0, 32'd1024,       90,  23, 1'b0},
        '{1'b0, 32'd1,          180, 8,  1'b1},
        '{1'b0, 32'd2000000000, 40,  8,  1'b0},
        '{1'b0, 32'd2000000001, 40,  8,  1'b0},
        '{1'b0, 32'd0,          40,  4,  1'b0},
        '{1'b0, 32'd5000,       40,  12, 1'b0},
        '{1'b1, 32'd0,          60,  20, 1'b0},
        '{1'b0, 32'hFFFFFFFF,   30,  23, 1'b0},
        '{1'b0, 32'h80000000,   30,  23, 1'b0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    twsa_pkg::in_t     in_data;
    logic              out_valid;
    logic              out_ready;
    twsa_pkg::out_t    out_data;
    logic              cfg_wr_en;
    logic [RW-1:0]     cfg_wr_data;

    // predictor state
    logic [RW-1:0]     rate_ring [twsa_pkg::WINDOW_DEPTH];
    int unsigned       fill_ptr     = 0;
    bit                ring_wrapped = 1'b0;
    logic [RW-1:0]     peak_rate    = '0;
    logic [RW-1:0]     floor_reg    = twsa_pkg::FLOOR_RESET;

    twsa_pkg::out_t pending_stats [$];
    int   mismatches   = 0;
    int   cycle_count  = 0;
    bit   steady       = 1'b0;
    bit   hold_pending = 1'b0;

    traffic_window_stats_autoscale dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("traffic_window_stats_autoscale_tb: errors");
            $finish;
        end
    end

    function automatic logic [RW-1:0] bps_of(logic [BW-1:0] bytes);
        logic [BW-1:0] clipped;
        clipped = (bytes > twsa_pkg::BYTES_SAT) ? twsa_pkg::BYTES_SAT : bytes;
        return RW'(clipped) * twsa_pkg::BPS_PER_BYTE;
    endfunction

    // smallest {1,2,5} x 10^k not below v, else v itself
    function automatic logic [RW-1:0] round_scale(logic [RW-1:0] v);
        logic [63:0] decade;
        logic [63:0] cand;
        decade = 64'd1;
        for (int k = 0; k < 10; k++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                cand = MANTISSA[s] * decade;
                if (cand > SCALE_TOP)
                    return v;
                if (cand >= 64'(v))
                    return cand[RW-1:0];
            end
            decade = decade * 64'd10;
        end
        return v;
    endfunction

    function automatic twsa_pkg::out_t compute_window_stats(twsa_pkg::in_t x);
        logic [RW-1:0]     combined;
        logic [RW-1:0]     wmax;
        logic [RW-1:0]     vmax;
        logic [63:0]       sum;
        int unsigned       count;
        twsa_pkg::out_t    r;
        combined = bps_of(x.in_bytes) + bps_of(x.out_bytes);
        rate_ring[fill_ptr] = combined;
        fill_ptr = (fill_ptr + 1) % twsa_pkg::WINDOW_DEPTH;
        if (fill_ptr == 0)
            ring_wrapped = 1'b1;
        if (combined > peak_rate)
            peak_rate = combined;
        count = ring_wrapped ? twsa_pkg::WINDOW_DEPTH : fill_ptr;
        sum   = '0;
        wmax  = '0;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (rate_ring[i] > wmax)
                wmax = rate_ring[i];
            sum = sum + 64'(rate_ring[i]);
        end
        vmax = (wmax > floor_reg) ? wmax : floor_reg;
        r.window_max    = wmax;
        r.window_avg    = RW'(sum / 64'(count));
        r.session_peak  = peak_rate;
        r.display_scale = round_scale(vmax);
        return r;
    endfunction

    function automatic logic [BW-1:0] rand_bytes(int cap_bits);
        logic [BW-1:0] mask;
        int            pick;
        mask = (cap_bits >= BW) ? '1 : BW'((1 << cap_bits) - 1);
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return mask;
        // straddle the saturation point
        if (cap_bits >= BW && pick < 30)
            return twsa_pkg::BYTES_SAT - BW'(2) + BW'($urandom_range(4));
        return BW'($urandom) & mask;
    endfunction

    // offer one transaction and hold it until taken
    task automatic send_item(twsa_pkg::in_t x, bit typed, twsa_pkg::out_t typed_stats);
        twsa_pkg::out_t predicted;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = compute_window_stats(x);
        pending_stats.push_back(typed ? typed_stats : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_floor(logic [RW-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        floor_reg = value;
    endtask

    task automatic check_field(string name, logic [RW-1:0] want,
                               logic [RW-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        twsa_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result transaction: %h", out_data);
            end
            else
            begin
                want = pending_stats.pop_front();
                check_field("window_max", want.window_max, out_data.window_max);
                check_field("window_avg", want.window_avg, out_data.window_avg);
                check_field("session_peak", want.session_peak, out_data.session_peak);
                check_field("display_scale", want.display_scale, out_data.display_scale);
            end
        end
    end

    // output backpressure, with one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        twsa_pkg::in_t     item;
        logic [RW-1:0]     fl;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_FLOOR)
            begin
                wait_drained();
                write_floor(directed_rows[r].floor_val);
            end
            else
            begin
                item.in_bytes  = directed_rows[r].in_b;
                item.out_bytes = directed_rows[r].out_b;
                send_item(item, directed_rows[r].typed, directed_rows[r].stats);
            end
        end

        foreach (traffic_phases[p])
        begin
            wait_drained();
            fl = traffic_phases[p].random_floor ? RW'($urandom_range(32'h80000000, 1))
                                                : traffic_phases[p].floor_val;
            write_floor(fl);
            steady = traffic_phases[p].steady_run;
            for (int n = 0; n < traffic_phases[p].count; n++)
            begin
                // stall the output long enough to back up the input side
                if (p == 0 && n == 10)
                    hold_pending = 1'b1;
                item.in_bytes  = rand_bytes(traffic_phases[p].cap_bits);
                item.out_bytes = rand_bytes(traffic_phases[p].cap_bits);
                send_item(item, 1'b0, '0);
            end
            steady = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pending_stats.size();
        if (mismatches == 0)
            $display("traffic_window_stats_autoscale_tb: clean");
        else
            $display("traffic_window_stats_autoscale_tb: errors");
        $finish;
    end

endmodule
